>>> rtl/core/sbmq_pkg.sv
// ----------------------------------------------------------------------------
// sbmq_pkg: shared buffer multi-queue package
// Sizes, link encoding, operation and status codes, and the queue table
// write port type shared by the control and table modules.
// ----------------------------------------------------------------------------
package sbmq_pkg;

   localparam int SLOTS   = 64;
   localparam int QUEUES  = 4;
   localparam int VALUE_W = 32;

   // slot address, and link wide enough to hold the null marker SLOTS
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = '1;

   typedef struct packed {
      logic              head_we;
      logic              tail_we;
      logic [QIDX_W-1:0] idx;
      logic [LINK_W-1:0] head;
      logic [SLOT_W-1:0] tail;
   } qtab_wr_type;

endpackage

>>> rtl/core/sbmq_ram.sv
// ----------------------------------------------------------------------------
// sbmq_ram: generic single-write, single-read synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sbmq_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sbmq_queue_table.sv
// ----------------------------------------------------------------------------
// sbmq_queue_table: per-queue head and tail pointers
// Heads reset to the null link; tails are valid only while a queue holds data.
// ----------------------------------------------------------------------------
module sbmq_queue_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sbmq_pkg::QIDX_W-1:0]         rd_idx,
   output logic [sbmq_pkg::LINK_W-1:0]         rd_head,
   output logic [sbmq_pkg::SLOT_W-1:0]         rd_tail,
   input  sbmq_pkg::qtab_wr_type               wr
);

   logic [sbmq_pkg::LINK_W-1:0] head_ff [sbmq_pkg::QUEUES];
   logic [sbmq_pkg::SLOT_W-1:0] tail_ff [sbmq_pkg::QUEUES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sbmq_pkg::QUEUES; i++) begin
            head_ff[i] <= sbmq_pkg::NULL_LINK;
         end
      end else if (wr.head_we) begin
         head_ff[wr.idx] <= wr.head;
      end
   end

   // tails carry no reset
   always_ff @(posedge clock) begin
      if (wr.tail_we) begin
         tail_ff[wr.idx] <= wr.tail;
      end
   end

   assign rd_head = head_ff[rd_idx];
   assign rd_tail = tail_ff[rd_idx];

endmodule

>>> rtl/core/shared_buffer_multi_queue.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue: several FIFO queues in one linked slot store
// Enqueue and dequeue commands against QUEUES queues sharing SLOTS slots.
// ----------------------------------------------------------------------------
// A command (enqueue req_value_in, or dequeue) is taken when start is high and
// busy is low. Each command runs an accept cycle, which issues the read of the
// slot link RAM, and then an execute cycle, which uses that link to update the
// free list or the queue head. The answer appears as a one-cycle rsp_valid
// strobe in the cycle after execute; busy is high through execute and is
// already low then, so the next command can be taken while the answer shows.
// The receiver cannot stall: sample the result in the cycle rsp_valid is
// high. After reset, busy stays high while the link RAM is swept to build
// the initial free list 0 -> 1 -> ... -> SLOTS-1. Status is 0 ok, 1 store
// full (or bad queue number) on enqueue, 2 queue empty (or bad queue number)
// on dequeue, where value_out reads -1; enqueues answer value_out 0.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_type,
   input  logic [1:0]          req_queue_id,
   input  logic signed [31:0]  req_value_in,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_value_out,
   output logic [1:0]          rsp_status
);

   localparam int SLOT_W = sbmq_pkg::SLOT_W;
   localparam int LINK_W = sbmq_pkg::LINK_W;
   localparam int QIDX_W = sbmq_pkg::QIDX_W;
   localparam int VALUE_W = sbmq_pkg::VALUE_W;

   // controller states
   localparam logic [1:0] S_INIT = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [SLOT_W-1:0]       init_cnt_ff, init_cnt_in;
   logic [LINK_W-1:0]       free_head_ff, free_head_in;
   logic                    op_ff, op_in;
   logic [QIDX_W-1:0]       qidx_ff, qidx_in;
   logic                    ok_ff, ok_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;

   logic                    accept;
   logic                    q_valid;
   logic                    free_ok;
   logic                    head_ok;
   logic                    enq_ok;
   logic                    deq_ok;
   logic [QIDX_W-1:0]       req_idx;

   logic [QIDX_W-1:0]       tab_rd_idx;
   logic [LINK_W-1:0]       tab_head;
   logic [SLOT_W-1:0]       tab_tail;
   sbmq_pkg::qtab_wr_type   tab_wr;

   logic                    link_we;
   logic [SLOT_W-1:0]       link_waddr;
   logic [LINK_W-1:0]       link_wdata;
   logic [SLOT_W-1:0]       link_raddr;
   logic [LINK_W-1:0]       link_rdata;
   logic [LINK_W-1:0]       link_next;

   logic                    val_we;
   logic [VALUE_W-1:0]      val_rdata;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign req_idx = QIDX_W'(req_queue_id);
   assign q_valid = int'(req_queue_id) < sbmq_pkg::QUEUES;
   assign free_ok = free_head_ff < sbmq_pkg::NULL_LINK;
   assign head_ok = tab_head < sbmq_pkg::NULL_LINK;
   assign enq_ok  = accept && (req_type == sbmq_pkg::OP_ENQ) && q_valid && free_ok;
   assign deq_ok  = accept && (req_type == sbmq_pkg::OP_DEQ) && q_valid && head_ok;

   // look at the incoming queue while idle, the latched one while executing
   assign tab_rd_idx = (state_ff == S_IDLE) ? req_idx : qidx_ff;

   // treat any out-of-range link as null
   assign link_next = (link_rdata < sbmq_pkg::NULL_LINK) ? link_rdata : sbmq_pkg::NULL_LINK;

   // link read: next free slot for enqueue, successor of head for dequeue
   assign link_raddr = (req_type == sbmq_pkg::OP_ENQ) ? free_head_ff[SLOT_W-1:0]
                                                     : tab_head[SLOT_W-1:0];

   // link write port: init sweep, append behind tail, or push freed slot
   always_comb begin
      link_we    = 1'b0;
      link_waddr = init_cnt_ff;
      link_wdata = LINK_W'(init_cnt_ff) + LINK_W'(1);
      priority if (state_ff == S_INIT) begin
         link_we = 1'b1;
      end else if (enq_ok && head_ok) begin
         link_we    = 1'b1;
         link_waddr = tab_tail;
         link_wdata = free_head_ff;
      end else if (state_ff == S_EXEC && op_ff == sbmq_pkg::OP_DEQ && ok_ff) begin
         link_we    = 1'b1;
         link_waddr = slot_ff;
         link_wdata = free_head_ff;
      end
   end

   assign val_we = enq_ok;

   // queue table updates: enqueue at accept, dequeue head advance at execute
   always_comb begin
      tab_wr.head_we = 1'b0;
      tab_wr.tail_we = 1'b0;
      tab_wr.idx     = req_idx;
      tab_wr.head    = free_head_ff;
      tab_wr.tail    = free_head_ff[SLOT_W-1:0];
      if (enq_ok) begin
         tab_wr.tail_we = 1'b1;
         tab_wr.head_we = !head_ok;
      end else if (state_ff == S_EXEC && op_ff == sbmq_pkg::OP_DEQ && ok_ff) begin
         tab_wr.head_we = 1'b1;
         tab_wr.idx     = qidx_ff;
         // last entry leaves: the queue drops to empty
         tab_wr.head    = (slot_ff == tab_tail) ? sbmq_pkg::NULL_LINK : link_next;
      end
   end

   // sequencer, free list head and result registers
   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      free_head_in  = free_head_ff;
      op_in         = op_ff;
      qidx_in       = qidx_ff;
      ok_in         = ok_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_INIT: begin
            init_cnt_in = init_cnt_ff + SLOT_W'(1);
            if (init_cnt_ff == SLOT_W'(sbmq_pkg::SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
               op_in    = req_type;
               qidx_in  = req_idx;
               ok_in    = enq_ok || deq_ok;
               slot_in  = (req_type == sbmq_pkg::OP_ENQ) ? free_head_ff[SLOT_W-1:0]
                                                          : tab_head[SLOT_W-1:0];
            end
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (op_ff == sbmq_pkg::OP_ENQ) begin
               rsp_value_in  = '0;
               rsp_status_in = ok_ff ? sbmq_pkg::ST_OK : sbmq_pkg::ST_FULL;
               if (ok_ff) begin
                  free_head_in = link_next;
               end
            end else begin
               rsp_value_in  = ok_ff ? $signed(val_rdata) : sbmq_pkg::EMPTY_VALUE;
               rsp_status_in = ok_ff ? sbmq_pkg::ST_OK : sbmq_pkg::ST_EMPTY;
               if (ok_ff) begin
                  free_head_in = LINK_W'(slot_ff);
               end
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds, no reset
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      qidx_ff       <= qidx_in;
      ok_ff         <= ok_in;
      slot_ff       <= slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   sbmq_queue_table u_queue_table (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (tab_rd_idx),
      .rd_head (tab_head),
      .rd_tail (tab_tail),
      .wr      (tab_wr)
   );

   sbmq_ram #(
      .DEPTH  (sbmq_pkg::SLOTS),
      .DATA_W (LINK_W),
      .ADDR_W (SLOT_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   sbmq_ram #(
      .DEPTH  (sbmq_pkg::SLOTS),
      .DATA_W (VALUE_W),
      .ADDR_W (SLOT_W)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (free_head_ff[SLOT_W-1:0]),
      .wr_data (req_value_in),
      .rd_addr (tab_head[SLOT_W-1:0]),
      .rd_data (val_rdata)
   );

`ifndef ASSERT_OFF
   // a result beat only follows an execute cycle
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_EXEC)
      else $error("result beat without execute cycle");

   // an accepted command is executed in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted command not executed");

   // free list head is a slot or the null marker
   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      free_head_ff <= sbmq_pkg::NULL_LINK)
      else $error("free list head out of range");

   // an empty answer always carries the empty value
   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == sbmq_pkg::ST_EMPTY) |-> rsp_value_out == sbmq_pkg::EMPTY_VALUE)
      else $error("empty status with wrong value");
`endif

endmodule
